/* rtl/dics_pkg.sv */
// Shared types, codes and constants for the draw item cull and key sort block.
`default_nettype none

package dics_pkg;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int LAYER_W    = 4;
    localparam int ORDER_W    = 32;
    localparam int TEXTURE_W  = 28;
    localparam int TAG_W      = 32;
    localparam int COORD_W    = 32;
    localparam int STATUS_W   = 3;
    localparam int KEY_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 224;
    localparam int M_TDATA_W  = 96;

    localparam int CAPACITY_DEF = 256;

    // Actions carried in s_tuser
    localparam logic [ACTION_W-1:0] ACT_SUBMIT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE   = 2'd3;

    // Result status carried in m_tuser
    localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CULLED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RETURNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CULL_MIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_MIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_MAX_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CULL_MAX_Y = 2'd3;

    localparam logic signed [COORD_W-1:0] CULL_MIN_RESET = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] CULL_MAX_RESET = 32'sh7FFF_FFFF;

    localparam logic [ORDER_W-1:0] FLIP_NEG = 32'hFFFF_FFFF;
    localparam logic [ORDER_W-1:0] FLIP_POS = 32'h8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
    } cull_box_t;

    // Command broadcast to every cell of the ring
    typedef struct packed {
        logic             insert;
        logic             rotate;
        logic             clear;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } cell_cmd_t;

    // Content of one cell: occupied flag, logical-start marker, key and tag
    typedef struct packed {
        logic             occ;
        logic             head;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } cell_state_t;

endpackage

`default_nettype wire

/* rtl/draw_item_cull_and_key_sort.sv */
// Top level: cull test, sorted ring of key cells, read-out and stream ports.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  s       | in        | s_tvalid/s_tready  | tuser: action; tdata: layer, order_bits,
//          |           |                    |   texture_id, entity_tag, dest_x/y/w/h
//  m       | out       | m_tvalid/m_tready  | tuser: status; tdata: sort_key, item_tag;
//          |           |                    |   tlast: last
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data (cull box registers)
//
// One item per cycle sustained while results are taken; an item's result passes through
// the input stage, then the output register, before it can leave.
// Every cell compares its key with the new key in the same cycle, so an insert does not
// depend on the fill; a read takes cell 0 and rotates the ring by one place.
// Reset empties the ring at once (no clearing pass) and sets the cull box to its widest.
// A stalled result holds in the output register; the input stage takes an item while it is
// empty or while that register is free or being emptied.
`default_nettype none

module draw_item_cull_and_key_sort
#(
    parameter int CAPACITY = dics_pkg::CAPACITY_DEF
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [3:0] layer, [35:4] order_bits, [63:36] texture_id, [95:64] entity_tag,
    // [127:96] dest_x, [159:128] dest_y, [191:160] dest_w, [223:192] dest_h
    input  wire logic [dics_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] action
    input  wire logic [dics_pkg::ACTION_W-1:0]     s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [63:0] sort_key, [95:64] item_tag
    output logic [dics_pkg::M_TDATA_W-1:0]         m_tdata,
    // [2:0] status
    output logic [dics_pkg::STATUS_W-1:0]          m_tuser,
    output logic                                   m_tlast,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dics_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dics_pkg::COORD_W-1:0]      cfg_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Configuration
    dics_pkg::cull_box_t box_reg, box_next;

    // Input stage
    logic                              s1_valid_reg, s1_valid_next;
    logic [dics_pkg::ACTION_W-1:0]     s1_action_reg;
    logic                              s1_visible_reg;
    logic [dics_pkg::KEY_W-1:0]        s1_key_reg;
    logic [dics_pkg::TAG_W-1:0]        s1_tag_reg;

    // Store bookkeeping
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [CNT_W-1:0]                  rp_reg, rp_next;

    // Output register
    logic                              m_valid_reg, m_valid_next;
    logic [dics_pkg::STATUS_W-1:0]     m_status_reg, res_status;
    logic [dics_pkg::KEY_W-1:0]        m_key_reg, res_key;
    logic [dics_pkg::TAG_W-1:0]        m_tag_reg, res_tag;
    logic                              m_last_reg, res_last;

    logic                              s_acc;
    logic                              exec;
    logic                              in_visible;
    logic [dics_pkg::KEY_W-1:0]        in_key;
    dics_pkg::cell_cmd_t               cmd;
    dics_pkg::cell_state_t             cells [CAPACITY];
    logic                              cell_gt [CAPACITY];

    assign cfg_ready = 1'b1;

    // Advance the input stage when the output register is free or being taken
    assign exec     = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || exec;
    assign s_acc    = s_tvalid && s_tready;

    dics_cull u_cull
    (
        .box        (box_reg),
        .dest_x     (s_tdata[127:96]),
        .dest_y     (s_tdata[159:128]),
        .dest_w     (s_tdata[191:160]),
        .dest_h     (s_tdata[223:192]),
        .layer      (s_tdata[3:0]),
        .order_bits (s_tdata[35:4]),
        .texture_id (s_tdata[63:36]),
        .visible    (in_visible),
        .key        (in_key)
    );

    always_comb
    begin
        box_next = box_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                dics_pkg::REG_CULL_MIN_X: box_next.min_x = cfg_data;
                dics_pkg::REG_CULL_MIN_Y: box_next.min_y = cfg_data;
                dics_pkg::REG_CULL_MAX_X: box_next.max_x = cfg_data;
                dics_pkg::REG_CULL_MAX_Y: box_next.max_y = cfg_data;
            endcase
        end
    end

    assign s1_valid_next = s_acc ? 1'b1 : (exec ? 1'b0 : s1_valid_reg);
    assign m_valid_next  = exec ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // Execute one item against the ring
    always_comb
    begin
        cmd        = '0;
        cmd.key    = s1_key_reg;
        cmd.tag    = s1_tag_reg;
        res_status = dics_pkg::ST_ACCEPTED;
        res_key    = '0;
        res_tag    = '0;
        res_last   = 1'b0;
        count_next = count_reg;
        rp_next    = rp_reg;
        if (exec)
        begin
            unique case (s1_action_reg)
                dics_pkg::ACT_SUBMIT:
                begin
                    if (!s1_visible_reg)
                    begin
                        res_status = dics_pkg::ST_CULLED;
                    end
                    else if (count_reg == CNT_W'(CAPACITY))
                    begin
                        res_status = dics_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                dics_pkg::ACT_READ:
                begin
                    // Cell 0 always holds the entry at the read position
                    if (rp_reg < count_reg)
                    begin
                        res_status = dics_pkg::ST_RETURNED;
                        res_key    = cells[0].key;
                        res_tag    = cells[0].tag;
                        res_last   = ((rp_reg + CNT_W'(1)) == count_reg);
                        cmd.rotate = 1'b1;
                        rp_next    = rp_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res_status = dics_pkg::ST_EMPTY;
                    end
                end
                dics_pkg::ACT_CLEAR:
                begin
                    cmd.clear  = 1'b1;
                    count_next = '0;
                    rp_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Ring of cells: insert shifts towards higher cells, read rotates towards cell 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int PREV = (i + CAPACITY - 1) % CAPACITY;
        localparam int NEXT = (i + 1) % CAPACITY;

        dics_cell #(.IS_FIRST(i == 0)) u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_state (cells[PREV]),
            .prev_gt    (cell_gt[PREV]),
            .next_state (cells[NEXT]),
            .state      (cells[i]),
            .gt         (cell_gt[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.min_x <= dics_pkg::CULL_MIN_RESET;
            box_reg.min_y <= dics_pkg::CULL_MIN_RESET;
            box_reg.max_x <= dics_pkg::CULL_MAX_RESET;
            box_reg.max_y <= dics_pkg::CULL_MAX_RESET;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            count_reg     <= '0;
            rp_reg        <= '0;
        end
        else
        begin
            box_reg      <= box_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            count_reg    <= count_next;
            rp_reg       <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_action_reg  <= s_tuser;
            s1_visible_reg <= in_visible;
            s1_key_reg     <= in_key;
            s1_tag_reg     <= s_tdata[95:64];
        end
        if (exec)
        begin
            m_status_reg <= res_status;
            m_key_reg    <= res_key;
            m_tag_reg    <= res_tag;
            m_last_reg   <= res_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_tag_reg, m_key_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

/* rtl/dics_cull.sv */
// Cull test of a destination rectangle and sort key formation.
`default_nettype none

module dics_cull
(
    input  wire dics_pkg::cull_box_t                     box,
    input  wire logic signed [dics_pkg::COORD_W-1:0]     dest_x,
    input  wire logic signed [dics_pkg::COORD_W-1:0]     dest_y,
    input  wire logic signed [dics_pkg::COORD_W-1:0]     dest_w,
    input  wire logic signed [dics_pkg::COORD_W-1:0]     dest_h,
    input  wire logic [dics_pkg::LAYER_W-1:0]            layer,
    input  wire logic [dics_pkg::ORDER_W-1:0]            order_bits,
    input  wire logic [dics_pkg::TEXTURE_W-1:0]          texture_id,
    output logic                                         visible,
    output logic [dics_pkg::KEY_W-1:0]                   key
);

    logic signed [dics_pkg::COORD_W:0]   right_edge;
    logic signed [dics_pkg::COORD_W:0]   bottom_edge;
    logic [dics_pkg::ORDER_W-1:0]        flip;

    // Exact 33-bit sums
    assign right_edge  = {dest_x[dics_pkg::COORD_W-1], dest_x}
                       + {dest_w[dics_pkg::COORD_W-1], dest_w};
    assign bottom_edge = {dest_y[dics_pkg::COORD_W-1], dest_y}
                       + {dest_h[dics_pkg::COORD_W-1], dest_h};

    assign visible = (dest_x < box.max_x)
                  && (right_edge > $signed({box.min_x[dics_pkg::COORD_W-1], box.min_x}))
                  && (dest_y < box.max_y)
                  && (bottom_edge > $signed({box.min_y[dics_pkg::COORD_W-1], box.min_y}));

    // Flip so unsigned order follows IEEE single order
    assign flip = order_bits[dics_pkg::ORDER_W-1] ? dics_pkg::FLIP_NEG : dics_pkg::FLIP_POS;
    assign key  = {layer, order_bits ^ flip, texture_id};

endmodule

`default_nettype wire

/* rtl/dics_cell.sv */
// One cell of the sorted ring: holds one key and tag, shifts on insert and rotate.
`default_nettype none

module dics_cell
#(
    parameter bit IS_FIRST = 1'b0
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dics_pkg::cell_cmd_t   cmd,
    input  wire dics_pkg::cell_state_t prev_state,
    input  wire logic                  prev_gt,
    input  wire dics_pkg::cell_state_t next_state,
    output dics_pkg::cell_state_t      state,
    output logic                       gt
);

    logic                        occ_reg, occ_next;
    logic                        head_reg, head_next;
    logic [dics_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [dics_pkg::TAG_W-1:0]  tag_reg, tag_next;
    logic                        take_new;
    logic                        take_prev;

    // Empty cells count as greater than any key
    assign gt        = !occ_reg || (key_reg > cmd.key);
    assign take_new  = gt && (head_reg || !prev_gt);
    assign take_prev = !head_reg && prev_gt;

    always_comb
    begin
        occ_next  = occ_reg;
        head_next = head_reg;
        key_next  = key_reg;
        tag_next  = tag_reg;
        if (cmd.clear)
        begin
            occ_next  = 1'b0;
            head_next = IS_FIRST;
        end
        else if (cmd.rotate)
        begin
            occ_next  = next_state.occ;
            head_next = next_state.head;
            key_next  = next_state.key;
            tag_next  = next_state.tag;
        end
        else if (cmd.insert)
        begin
            if (take_new)
            begin
                occ_next = 1'b1;
                key_next = cmd.key;
                tag_next = cmd.tag;
            end
            else if (take_prev)
            begin
                occ_next = prev_state.occ;
                key_next = prev_state.key;
                tag_next = prev_state.tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= 1'b0;
            head_reg <= IS_FIRST;
        end
        else
        begin
            occ_reg  <= occ_next;
            head_reg <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign state = '{occ: occ_reg, head: head_reg, key: key_reg, tag: tag_reg};

endmodule

`default_nettype wire

/* rtl/dics_check.sv */
// Port-level checker for the draw item cull and key sort block, with its bind.
`default_nettype none

module dics_check
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [dics_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic [dics_pkg::STATUS_W-1:0]     m_tuser,
    input  wire logic                              m_tlast
);

    // No result is offered while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result offered during reset");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // Only a returned item carries key, tag and last
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != dics_pkg::ST_RETURNED) |-> (m_tdata == '0) && !m_tlast)
        else $error("non-read result with payload");

    // Status stays within its codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= dics_pkg::ST_EMPTY))
        else $error("undefined status code");

endmodule

bind draw_item_cull_and_key_sort dics_check u_dics_check
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

/* dv/sort_queue_checker.sv */
// Checker for the draw item cull and key sort block: predicts results and compares them.
module sort_queue_checker
    import dics_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic [ACTION_W-1:0]    s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_TDATA_W-1:0]   m_tdata,
    input  wire logic [STATUS_W-1:0]    m_tuser,
    input  wire logic                   m_tlast,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [COORD_W-1:0]     cfg_data,
    output int                          mismatch_count,
    output int                          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key;
        logic [TAG_W-1:0]    tag;
        logic                last;
    } draw_result_t;

    logic [KEY_W-1:0] key_cells [CAPACITY];
    logic [TAG_W-1:0] tag_cells [CAPACITY];
    int unsigned      filled;
    int unsigned      read_at;
    cull_box_t        box;
    draw_result_t     pending_results [$];
    draw_result_t     want;
    draw_result_t     got;
    int               fails = 0;

    function automatic logic [KEY_W-1:0] sort_key_of(logic [LAYER_W-1:0] layer,
                                                     logic [ORDER_W-1:0] order,
                                                     logic [TEXTURE_W-1:0] tex);
        logic [ORDER_W-1:0] ranked;
        ranked = order ^ (order[ORDER_W-1] ? FLIP_NEG : FLIP_POS);
        return {layer, ranked, tex};
    endfunction

    // Sums are taken in 64 bits so nothing wraps
    function automatic bit in_cull_box(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                                       logic signed [COORD_W-1:0] w, logic signed [COORD_W-1:0] h);
        longint sx, sy, sw, sh;
        sx = x;
        sy = y;
        sw = w;
        sh = h;
        return sx < longint'($signed(box.max_x)) && sx + sw > longint'($signed(box.min_x)) &&
               sy < longint'($signed(box.max_y)) && sy + sh > longint'($signed(box.min_y));
    endfunction

    function automatic draw_result_t apply_item(logic [ACTION_W-1:0] action,
                                                logic [S_TDATA_W-1:0] data);
        draw_result_t     r;
        logic [KEY_W-1:0] k;
        int unsigned      pos;
        r = '0;
        case (action)
            ACT_SUBMIT:
            begin
                if (!in_cull_box(data[127:96], data[159:128], data[191:160], data[223:192]))
                begin
                    r.status = ST_CULLED;
                end
                else if (filled >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    k = sort_key_of(data[3:0], data[35:4], data[63:36]);
                    pos = filled;
                    // shift strictly greater keys up: equal keys stay in arrival order
                    while (pos > 0 && key_cells[pos-1] > k)
                    begin
                        key_cells[pos] = key_cells[pos-1];
                        tag_cells[pos] = tag_cells[pos-1];
                        pos--;
                    end
                    key_cells[pos] = k;
                    tag_cells[pos] = data[95:64];
                    filled++;
                    r.status = ST_ACCEPTED;
                end
            end
            ACT_READ:
            begin
                if (read_at < filled)
                begin
                    r.status = ST_RETURNED;
                    r.key    = key_cells[read_at];
                    r.tag    = tag_cells[read_at];
                    r.last   = (read_at + 1 == filled);
                    read_at++;
                end
                else
                begin
                    r.status = ST_EMPTY;
                end
            end
            ACT_CLEAR:
            begin
                filled  = 0;
                read_at = 0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled        = 0;
            read_at       = 0;
            box.min_x     = CULL_MIN_RESET;
            box.min_y     = CULL_MIN_RESET;
            box.max_x     = CULL_MAX_RESET;
            box.max_y     = CULL_MAX_RESET;
            pending_results.delete();
            outstanding    <= 0;
            mismatch_count <= fails;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CULL_MIN_X: box.min_x = cfg_data;
                    REG_CULL_MIN_Y: box.min_y = cfg_data;
                    REG_CULL_MAX_X: box.max_x = cfg_data;
                    REG_CULL_MAX_Y: box.max_y = cfg_data;
                    default:        box = box;
                endcase
            end
            if (s_tvalid && s_tready)
                pending_results = {pending_results, apply_item(s_tuser, s_tdata)};
            if (m_tvalid && m_tready)
            begin
                got.status = m_tuser;
                got.key    = m_tdata[63:0];
                got.tag    = m_tdata[95:64];
                got.last   = m_tlast;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result item: status %0d", got.status);
                    fails++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fails++;
                    end
                    if (got.key !== want.key)
                    begin
                        $error("sort_key: expected %h, got %h", want.key, got.key);
                        fails++;
                    end
                    if (got.tag !== want.tag)
                    begin
                        $error("item_tag: expected %h, got %h", want.tag, got.tag);
                        fails++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        fails++;
                    end
                end
            end
            outstanding    <= pending_results.size();
            mismatch_count <= fails;
        end
    end

endmodule

/* dv/testbench.sv */
// Top of the testbench: clock, reset, stimulus, handshake idling and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dics_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 26;

    // Input item fields, packed exactly as s_tdata: layer in the lowest bits
    typedef struct packed {
        logic [COORD_W-1:0]   h;
        logic [COORD_W-1:0]   w;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   x;
        logic [TAG_W-1:0]     tag;
        logic [TEXTURE_W-1:0] tex;
        logic [ORDER_W-1:0]   order;
        logic [LAYER_W-1:0]   layer;
    } draw_fields_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b1;
    logic                   s_tvalid = 1'b0;
    wire                    s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [ACTION_W-1:0]    s_tuser = ACT_SUBMIT;
    wire                    m_tvalid;
    logic                   m_tready = 1'b0;
    wire  [M_TDATA_W-1:0]   m_tdata;
    wire  [STATUS_W-1:0]    m_tuser;
    wire                    m_tlast;
    logic                   cfg_valid = 1'b0;
    wire                    cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_CULL_MIN_X;
    logic [COORD_W-1:0]     cfg_data = '0;

    int           mismatches;
    int           outstanding;
    int           send_idle_pct = 24;
    int           recv_idle_pct = 65;
    int           cycle_count = 0;
    cull_box_t    aim;
    draw_fields_t prior = '0;

    draw_item_cull_and_key_sort dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sort_queue_checker checker_i
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatches),
        .outstanding    (outstanding)
    );

    always #4 clk = ~clk;

    // Receiver back-pressure: redraw tready at every falling edge
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Watchdog: give up well beyond the slowest correct run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("draw_item_cull_and_key_sort: mismatch");
            $finish;
        end
    end

    // Coordinate somewhere around [lo, hi], with the edges themselves and full-range noise
    function automatic logic [COORD_W-1:0] pick_coord(logic signed [COORD_W-1:0] lo,
                                                      logic signed [COORD_W-1:0] hi);
        longint from;
        longint span;
        from = longint'(lo) - 65536;
        span = longint'(hi) - from + 1;
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return lo;
            2:       return hi;
            3:       return hi - 1;
            default:
            begin
                if (span <= 0)
                    return $urandom;
                else
                    return 32'(from + longint'({$urandom, $urandom} % 64'(span)));
            end
        endcase
    endfunction

    // Extent that lands on, short of or past the box's near edge, or anywhere at all
    function automatic logic [COORD_W-1:0] pick_extent(logic [COORD_W-1:0] start,
                                                       logic [COORD_W-1:0] near_edge);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return '0;
            2:       return near_edge - start;
            3:       return 32'(-int'($urandom_range(1, 1 << 16)));
            default: return $urandom_range(1, 1 << 22);
        endcase
    endfunction

    // Random item aimed at the current cull box; sometimes repeat the last key with a new tag
    function automatic draw_fields_t random_fields();
        draw_fields_t       f;
        logic [ORDER_W-1:0] specials [8];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
                     32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000, 32'hBF80_0000};
        f.layer = LAYER_W'($urandom_range(0, 15));
        f.order = ($urandom_range(0, 3) == 0) ? specials[$urandom_range(0, 7)] : $urandom;
        f.tex   = 28'($urandom);
        f.tag   = $urandom;
        if ($urandom_range(0, 99) < 15)
        begin
            f.layer = prior.layer;
            f.order = prior.order;
            f.tex   = prior.tex;
        end
        f.x = pick_coord(aim.min_x, aim.max_x);
        f.w = pick_extent(f.x, aim.min_x);
        f.y = pick_coord(aim.min_y, aim.max_y);
        f.h = pick_extent(f.y, aim.min_y);
        prior = f;
        return f;
    endfunction

    // Present one item and hold it until taken; tvalid stays up for a following item
    task automatic send_item(logic [ACTION_W-1:0] action, draw_fields_t f);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic submit(logic [LAYER_W-1:0] layer, logic [ORDER_W-1:0] order,
                          logic [TEXTURE_W-1:0] tex, logic [TAG_W-1:0] tag,
                          logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                          logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
        draw_fields_t f;
        f = '{h: h, w: w, y: y, x: x, tag: tag, tex: tex, order: order, layer: layer};
        send_item(ACT_SUBMIT, f);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [COORD_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Program all four box registers back to back, then drop the write strobe
    task automatic set_box(cull_box_t b);
        aim = b;
        write_reg(REG_CULL_MIN_X, b.min_x);
        write_reg(REG_CULL_MIN_Y, b.min_y);
        write_reg(REG_CULL_MAX_X, b.max_x);
        write_reg(REG_CULL_MAX_Y, b.max_y);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop tvalid, wait for every expected result, then let the two-stage pipe empty
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin : stimulus
        draw_fields_t f;
        cull_box_t    b;
        int           pick;

        rst_n <= 1'b0;
        aim.min_x = CULL_MIN_RESET;
        aim.min_y = CULL_MIN_RESET;
        aim.max_x = CULL_MAX_RESET;
        aim.max_y = CULL_MAX_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, cull box at its reset extremes.
        // Read on an empty store, the undefined action, clear with nothing stored.
        send_item(ACT_READ, random_fields());
        send_item(ACT_NONE, random_fields());
        send_item(ACT_CLEAR, random_fields());
        // Keys at the field extremes: NaN, +0, -0 (just below +0), negative NaN, and a tie
        submit(4'hF, 32'h7FC0_0000, 28'hFFF_FFFF, 32'hFFFF_FFFF, '0, '0, 32'h1_0000, 32'h1_0000);
        submit(4'h0, 32'h0000_0000, 28'h000_0000, 32'h0000_0000, '0, '0, 32'h1_0000, 32'h1_0000);
        submit(4'h0, 32'h8000_0000, 28'h000_0000, 32'h0000_0001, '0, '0, 32'h1_0000, 32'h1_0000);
        submit(4'h0, 32'hFFFF_FFFF, 28'h000_0005, 32'h0000_0002, '0, '0, 32'h1_0000, 32'h1_0000);
        submit(4'h0, 32'h3F80_0000, 28'h000_0007, 32'h0000_0003, '0, '0, 32'h1_0000, 32'h1_0000);
        submit(4'h0, 32'h3F80_0000, 28'h000_0007, 32'h0000_0004, '0, '0, 32'h1_0000, 32'h1_0000);
        // Cull edges: left at the right edge, a sum that would wrap in 32 bits either way,
        // top at the bottom edge, and a height that stops exactly on the top edge
        submit(4'h1, 32'h1, 28'h1, 32'hA, 32'h7FFF_FFFF, '0, 32'h1_0000, 32'h1_0000);
        submit(4'h1, 32'h1, 28'h1, 32'hB, 32'h8000_0000, '0, 32'h8000_0000, 32'h1_0000);
        submit(4'h3, 32'h1, 28'h1, 32'hC, 32'h7FFF_FFFE, 32'h7FFF_FFFE,
               32'h7FFF_FFFF, 32'h7FFF_FFFF);
        submit(4'h1, 32'h1, 28'h1, 32'hD, '0, 32'h7FFF_FFFF, 32'h1_0000, 32'h1_0000);
        submit(4'h1, 32'h1, 28'h1, 32'hE, '0, 32'h8000_0000, 32'h1_0000, 32'h0);
        // Read partway, then insert below the read position so later entries shift up
        send_item(ACT_READ, random_fields());
        send_item(ACT_READ, random_fields());
        submit(4'h0, 32'hBF80_0000, 28'h000_0009, 32'h0000_000F, '0, '0, 32'h1_0000, 32'h1_0000);
        // Walk to the final entry, then clear and read the empty store
        repeat (6) send_item(ACT_READ, random_fields());
        send_item(ACT_CLEAR, random_fields());
        send_item(ACT_READ, random_fields());
        settle();

        // Random phases, one cull box each; idling shifts from sender-light to
        // receiver-light, and the last phase runs without gaps and fills the store
        for (int p = 0; p < 5; p++)
        begin
            send_idle_pct = (p < 2) ? 24 : (p < 4) ? 65 : 0;
            recv_idle_pct = (p < 2) ? 65 : (p < 4) ? 24 : 0;
            case (p)
                0:
                begin
                    b.min_x = 32'(-int'($urandom_range(0, 1 << 24)));
                    b.min_y = 32'(-int'($urandom_range(0, 1 << 24)));
                    b.max_x = b.min_x + $urandom_range(1, 1 << 25);
                    b.max_y = b.min_y + $urandom_range(1, 1 << 25);
                end
                1:
                begin
                    b.min_x = 32'h7FFF_0000;
                    b.max_x = CULL_MAX_RESET;
                    b.min_y = CULL_MIN_RESET;
                    b.max_y = 32'h8001_0000;
                end
                2:
                begin
                    b.min_x = $urandom;
                    b.min_y = $urandom;
                    b.max_x = $urandom;
                    b.max_y = $urandom;
                end
                3:
                begin
                    // inverted in x: max_x lies below min_x, so only rectangles that span the gap pass
                    b.min_x = 32'sd1 << 20;
                    b.max_x = -(32'sd1 << 20);
                    b.min_y = 32'(-int'($urandom_range(0, 1 << 20)));
                    b.max_y = $urandom_range(0, 1 << 20);
                end
                default:
                begin
                    b.min_x = CULL_MIN_RESET;
                    b.min_y = CULL_MIN_RESET;
                    b.max_x = CULL_MAX_RESET;
                    b.max_y = CULL_MAX_RESET;
                end
            endcase
            set_box(b);

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                send_item((pick < 55) ? ACT_SUBMIT : (pick < 90) ? ACT_READ :
                          (pick < 95) ? ACT_CLEAR : ACT_NONE, random_fields());
            end

            if (p == 4)
            begin
                // Fill to capacity with visible rectangles, then push past it
                send_item(ACT_CLEAR, random_fields());
                for (int n = 0; n < CAPACITY_DEF + 2; n++)
                begin
                    f = random_fields();
                    f.x = $urandom_range(0, 1 << 30);
                    f.y = $urandom_range(0, 1 << 30);
                    f.w = $urandom_range(1, 1 << 20);
                    f.h = $urandom_range(1, 1 << 20);
                    send_item(ACT_SUBMIT, f);
                end
                // A culled item on a full store still answers culled
                f = random_fields();
                f.x = CULL_MAX_RESET;
                send_item(ACT_SUBMIT, f);
                repeat (30) send_item(ACT_READ, random_fields());
                f.x = '0;
                f.y = '0;
                f.w = 32'h1_0000;
                f.h = 32'h1_0000;
                send_item(ACT_SUBMIT, f);
                send_item(ACT_CLEAR, random_fields());
                send_item(ACT_READ, random_fields());
            end
            settle();
        end

        if (mismatches == 0)
            $display("draw_item_cull_and_key_sort: match");
        else
            $display("draw_item_cull_and_key_sort: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dics_pkg.sv
rtl/dics_cull.sv
rtl/dics_cell.sv
rtl/draw_item_cull_and_key_sort.sv
rtl/dics_check.sv
dv/sort_queue_checker.sv
dv/testbench.sv
